// File: src/rspt_pkg.sv
// ----------------------------------------------------------------------------
// rspt_pkg: shared types and constants of the range sum tree
// Tree geometry, action codes and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rspt_pkg;

	// tree geometry
	localparam int ELEMENTS = 1024;
	localparam int NODE_W   = $clog2(2 * ELEMENTS);
	localparam int PTR_W    = NODE_W + 1;

	// fixed field widths
	localparam int ACT_W  = 2;
	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;
	localparam int SIZE_W = 11;
	localparam int LIM_W  = (PTR_W > SIZE_W) ? PTR_W : SIZE_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD     = 2'd0,
		ACT_WITHDRAW = 2'd1,
		ACT_DEPOSIT  = 2'd2,
		ACT_RANGE    = 2'd3
	} act_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_LEAF_RD,
		OP_LEAF_WR,
		OP_SIB_RD,
		OP_PARENT_WR,
		OP_RS_INIT,
		OP_L_RD,
		OP_ACC,
		OP_R_RD,
		OP_SHIFT,
		OP_ACC_SHIFT,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		act_t act;
		logic at_root;
		logic l_lt_r;
		logic l_odd;
		logic r_odd;
		logic clr_last;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: src/rspt_item_if.sv
// ----------------------------------------------------------------------------
// rspt_item_if: request channel of the range sum tree
// Valid/ready channel carrying one action word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspt_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [9:0]  index;
	logic [9:0]  upper_index;
	logic [31:0] amount;

	modport source (output valid, action, index, upper_index, amount, input ready);
	modport sink   (input valid, action, index, upper_index, amount, output ready);
endinterface

`default_nettype wire

// File: src/rspt_result_if.sv
// ----------------------------------------------------------------------------
// rspt_result_if: response channel of the range sum tree
// Valid/ready channel carrying one value and error flag per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspt_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        error;

	modport source (output valid, value, error, input ready);
	modport sink   (input valid, value, error, output ready);
endinterface

`default_nettype wire

// File: src/rspt_dp.sv
// ----------------------------------------------------------------------------
// rspt_dp: datapath of the range sum tree
// Node memory, walk pointers, accumulator, size register and output word.
// ----------------------------------------------------------------------------
`default_nettype none

module rspt_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rspt_pkg::dp_cmd_t         cmd,
	output rspt_pkg::dp_stat_t             stat,
	input  wire logic                      cfg_we,
	input  wire logic [rspt_pkg::SIZE_W-1:0] cfg_data,
	input  wire logic [rspt_pkg::ACT_W-1:0]  item_action,
	input  wire logic [rspt_pkg::IDX_W-1:0]  item_index,
	input  wire logic [rspt_pkg::IDX_W-1:0]  item_upper,
	input  wire logic [rspt_pkg::DATA_W-1:0] item_amount,
	input  wire logic                      result_ready,
	output logic                           result_valid,
	output logic [rspt_pkg::DATA_W-1:0]    result_value,
	output logic                           result_error
);
	import rspt_pkg::*;

	// node memory: node k holds children 2k and 2k+1, leaves at ELEMENTS+i
	logic [DATA_W-1:0] tree_mem [2*ELEMENTS];

	logic              mem_we;
	logic [NODE_W-1:0] mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic              mem_re;
	logic [NODE_W-1:0] mem_ra;
	logic [DATA_W-1:0] rd_q;

	// item and walk registers
	act_t              act_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [DATA_W-1:0] amt_q;
	logic [NODE_W-1:0] node_q;
	logic [DATA_W-1:0] cur_q;
	logic [PTR_W-1:0]  l_q;
	logic [PTR_W-1:0]  r_q;
	logic [DATA_W-1:0] acc_q;
	logic [SIZE_W-1:0] size_q;
	logic [NODE_W-1:0] clr_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_error_q;

	logic [LIM_W-1:0]  limit;
	logic [NODE_W-1:0] leaf_addr;
	logic [PTR_W-1:0]  r_dec;
	logic [DATA_W-1:0] leaf_new;
	logic [DATA_W-1:0] parent_sum;

	// effective size and index check
	assign limit = (LIM_W'(size_q) > LIM_W'(ELEMENTS)) ? LIM_W'(ELEMENTS) : LIM_W'(size_q);
	assign leaf_addr = NODE_W'(ELEMENTS) + NODE_W'(lo_q);
	assign r_dec = r_q - PTR_W'(1);
	assign parent_sum = cur_q + rd_q;

	always_comb begin
		unique case (act_q)
			ACT_LOAD:     leaf_new = amt_q;
			ACT_WITHDRAW: leaf_new = '0;
			ACT_DEPOSIT:  leaf_new = rd_q + amt_q;
			ACT_RANGE:    leaf_new = rd_q;
			default:      leaf_new = rd_q;
		endcase
	end

	// status back to the controller
	always_comb begin
		stat.bad      = (LIM_W'(lo_q) >= limit) || ((act_q == ACT_RANGE) && (LIM_W'(hi_q) >= limit));
		stat.act      = act_q;
		stat.at_root  = (node_q == NODE_W'(1));
		stat.l_lt_r   = (l_q < r_q);
		stat.l_odd    = l_q[0];
		stat.r_odd    = r_q[0];
		stat.clr_last = (clr_q == '1);
		stat.out_busy = out_valid_q && !result_ready;
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = node_q;
		mem_wd = leaf_new;
		mem_re = 1'b0;
		mem_ra = leaf_addr;
		unique case (cmd.op)
			OP_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			OP_LEAF_RD: mem_re = 1'b1;
			OP_LEAF_WR: mem_we = 1'b1;
			OP_SIB_RD: begin
				mem_re = 1'b1;
				mem_ra = node_q ^ NODE_W'(1);
			end
			OP_PARENT_WR: begin
				mem_we = 1'b1;
				mem_wa = node_q >> 1;
				mem_wd = parent_sum;
			end
			OP_L_RD: begin
				mem_re = 1'b1;
				mem_ra = l_q[NODE_W-1:0];
			end
			OP_R_RD: begin
				mem_re = 1'b1;
				mem_ra = r_dec[NODE_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tree_mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= tree_mem[mem_ra];
	end

	// walk registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				act_q <= act_t'(item_action);
				lo_q  <= item_index;
				hi_q  <= item_upper;
				amt_q <= item_amount;
				acc_q <= '0;
			end
			OP_LEAF_RD: node_q <= leaf_addr;
			OP_LEAF_WR: begin
				cur_q <= leaf_new;
				if (act_q == ACT_WITHDRAW)
					acc_q <= rd_q;
			end
			OP_PARENT_WR: begin
				cur_q  <= parent_sum;
				node_q <= node_q >> 1;
			end
			OP_RS_INIT: begin
				l_q <= PTR_W'(ELEMENTS) + PTR_W'(lo_q);
				r_q <= PTR_W'(ELEMENTS) + PTR_W'(hi_q) + PTR_W'(1);
			end
			OP_L_RD: l_q <= l_q + PTR_W'(1);
			OP_ACC:  acc_q <= acc_q + rd_q;
			OP_R_RD: r_q <= r_dec;
			OP_SHIFT: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
			end
			OP_ACC_SHIFT: begin
				acc_q <= acc_q + rd_q;
				l_q   <= l_q >> 1;
				r_q   <= r_q >> 1;
			end
			OP_OUT_LOAD: begin
				out_value_q <= acc_q;
				out_error_q <= stat.bad;
			end
			default: ;
		endcase
	end

	// size register and clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			clr_q  <= '0;
		end else begin
			if (cfg_we)
				size_q <= cfg_data;
			if (cmd.op == OP_CLEAR)
				clr_q <= clr_q + NODE_W'(1);
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_value = out_value_q;
	assign result_error = out_error_q;

endmodule

`default_nettype wire

// File: src/rspt_ctrl.sv
// ----------------------------------------------------------------------------
// rspt_ctrl: sequencer of the range sum tree
// Steps the datapath through the clearing sweep, the leaf-to-root update
// walk and the two-pointer range walk.
// ----------------------------------------------------------------------------
`default_nettype none

module rspt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire rspt_pkg::dp_stat_t stat,
	output rspt_pkg::dp_cmd_t       cmd
);
	import rspt_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_CHECK   = 11'b000_0000_0100,
		ST_LEAF_WR = 11'b000_0000_1000,
		ST_UP_RD   = 11'b000_0001_0000,
		ST_UP_WR   = 11'b000_0010_0000,
		ST_RS_L    = 11'b000_0100_0000,
		ST_RS_LA   = 11'b000_1000_0000,
		ST_RS_R    = 11'b001_0000_0000,
		ST_RS_RA   = 11'b010_0000_0000,
		ST_RESULT  = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and datapath command
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		item_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (stat.bad) begin
					state_d = ST_RESULT;
				end else if (stat.act == ACT_RANGE) begin
					cmd.op  = OP_RS_INIT;
					state_d = ST_RS_L;
				end else begin
					cmd.op  = OP_LEAF_RD;
					state_d = ST_LEAF_WR;
				end
			end
			ST_LEAF_WR: begin
				cmd.op  = OP_LEAF_WR;
				state_d = ST_UP_RD;
			end
			ST_UP_RD: begin
				priority if (stat.at_root) begin
					state_d = (stat.act == ACT_WITHDRAW) ? ST_RESULT : ST_IDLE;
				end else begin
					cmd.op  = OP_SIB_RD;
					state_d = ST_UP_WR;
				end
			end
			ST_UP_WR: begin
				cmd.op  = OP_PARENT_WR;
				state_d = ST_UP_RD;
			end
			ST_RS_L: begin
				priority if (!stat.l_lt_r) begin
					state_d = ST_RESULT;
				end else if (stat.l_odd) begin
					cmd.op  = OP_L_RD;
					state_d = ST_RS_LA;
				end else begin
					state_d = ST_RS_R;
				end
			end
			ST_RS_LA: begin
				cmd.op  = OP_ACC;
				state_d = ST_RS_R;
			end
			ST_RS_R: begin
				if (stat.r_odd) begin
					cmd.op  = OP_R_RD;
					state_d = ST_RS_RA;
				end else begin
					cmd.op  = OP_SHIFT;
					state_d = ST_RS_L;
				end
			end
			ST_RS_RA: begin
				cmd.op  = OP_ACC_SHIFT;
				state_d = ST_RS_L;
			end
			ST_RESULT: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register, sweep runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

`default_nettype wire

// File: src/range_sum_point_update_tree.sv
// ----------------------------------------------------------------------------
// range_sum_point_update_tree: counters with a range sum tree
// Keeps 1024 32-bit counters and a bottom-up tree of partial sums in one
// node memory. Load, withdraw and deposit update a leaf and its path to the
// root; range sum walks two pointers up the tree.
//
// Channels: item (action, index, upper_index, amount) and result (value,
// error), both valid/ready; a word moves when valid and ready are high.
// Config: cfg_we/cfg_data write the size in use (reset 1024); write only
// while the block is idle.
// Sequence: an update reads the leaf, writes it, then reads the sibling and
// writes the parent at each level up to the root; a withdraw then also loads
// its result word. A range sum walks two pointers up the tree level by level,
// and an out-of-range item goes straight to its error result. The node memory
// has a single read and single write port. One item is worked on at a time.
// Reset: a clearing sweep zeroes all 2048 nodes of the memory; item.ready
// stays low until it ends.
// Stall: a result waits in the output register; the next item is taken while
// it waits, and the block holds only if a second result is ready before the
// first is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module range_sum_point_update_tree (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rspt_pkg::SIZE_W-1:0] cfg_data,
	rspt_item_if.sink                        item,
	rspt_result_if.source                    result
);
	import rspt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	rspt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// node memory and walk datapath
	rspt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.item_action  (item.action),
		.item_index   (item.index),
		.item_upper   (item.upper_index),
		.item_amount  (item.amount),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.result_value (result.value),
		.result_error (result.error)
	);

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_sum_point_update_tree
// Sends load, withdraw, deposit and range sum words under several sizes in
// use, with random gaps on the item side and random stalls on the result
// side. A flat copy of the counters predicts each result word, and every
// result is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

// scoreboard: flat counter array plus the queue of result words still due
class counter_tree_ledger;
	typedef struct {
		logic [31:0] value;
		logic        error;
	} outcome_t;

	logic [31:0] counters [rspt_pkg::ELEMENTS];
	int unsigned live;
	outcome_t    due_results [$];
	int unsigned mismatches;

	function new();
		foreach (counters[i]) counters[i] = '0;
		live = rspt_pkg::ELEMENTS;
		mismatches = 0;
	endfunction

	// effective size is the register clamped to the array length
	function void set_size(logic [rspt_pkg::SIZE_W-1:0] sz);
		live = (sz > rspt_pkg::ELEMENTS) ? rspt_pkg::ELEMENTS : sz;
	endfunction

	// apply one accepted item word and queue the result it causes
	function void take_word(rspt_pkg::act_t act, logic [9:0] lo, logic [9:0] hi,
			logic [31:0] amt);
		outcome_t    o;
		logic [31:0] acc;
		o.value = '0;
		o.error = 1'b0;
		// any bad bound: error word, no change
		if (lo >= live || (act == rspt_pkg::ACT_RANGE && hi >= live)) begin
			o.error = 1'b1;
			due_results.push_back(o);
			return;
		end
		case (act)
			rspt_pkg::ACT_LOAD: counters[lo] = amt;
			rspt_pkg::ACT_DEPOSIT: counters[lo] = counters[lo] + amt;
			rspt_pkg::ACT_WITHDRAW: begin
				o.value = counters[lo];
				counters[lo] = '0;
				due_results.push_back(o);
			end
			default: begin
				// reversed bounds leave the total at zero
				acc = '0;
				for (int k = lo; k <= hi; k++) acc = acc + counters[k];
				o.value = acc;
				due_results.push_back(o);
			end
		endcase
	endfunction

	function void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10) $display("mismatch %0d at %0t: %s", mismatches, $time, msg);
	endfunction

	// compare one accepted result word with the oldest prediction
	function void check_word(logic [31:0] value, logic error);
		outcome_t o;
		if (due_results.size() == 0) begin
			note_mismatch($sformatf("unexpected result word value=%h error=%b", value, error));
			return;
		end
		o = due_results.pop_front();
		if (value !== o.value || error !== o.error)
			note_mismatch($sformatf("expected value=%h error=%b, got value=%h error=%b",
				o.value, o.error, value, error));
	endfunction
endclass

module tb;
	import rspt_pkg::*;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 64;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	rspt_item_if   item_ch ();
	rspt_result_if result_ch ();

	counter_tree_ledger ledger = new();

	bit quiet      = 1'b0;
	int stall_left = 0;
	int cycle_count = 0;

	range_sum_point_update_tree u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item_ch),
		.result   (result_ch)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(3, 1);
		if (r < 93) return $urandom_range(8, 4);
		return $urandom_range(60, 10);
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				ledger.take_word(act_t'(item_ch.action), item_ch.index,
					item_ch.upper_index, item_ch.amount);
			if (result_ch.valid && result_ch.ready)
				ledger.check_word(result_ch.value, result_ch.error);
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (quiet) begin
			stall_left = 0;
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if ($urandom_range(99) < 25) begin
			stall_left = pick_gap() - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// hold valid low, junk on the payload
	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			item_ch.valid       <= 1'b0;
			item_ch.action      <= ACT_W'($urandom);
			item_ch.index       <= IDX_W'($urandom);
			item_ch.upper_index <= IDX_W'($urandom);
			item_ch.amount      <= $urandom;
		end
	endtask

	// present one item word and wait for it to be taken
	task automatic send_word(act_t act, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
			logic [DATA_W-1:0] amt);
		@(negedge clk);
		item_ch.valid       <= 1'b1;
		item_ch.action      <= act;
		item_ch.index       <= lo;
		item_ch.upper_index <= hi;
		item_ch.amount      <= amt;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// stop sending until every due result word has come, then let updates finish
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (ledger.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] sz);
		drain();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= sz;
		@(negedge clk);
		cfg_we <= 1'b0;
		ledger.set_size(sz);
	endtask

	// random item word shaped around the size in use
	task automatic send_random();
		int unsigned       live;
		int unsigned       r;
		logic [IDX_W-1:0]  lo;
		logic [IDX_W-1:0]  hi;
		logic [DATA_W-1:0] amt;
		act_t              act;
		live = ledger.live;
		r = $urandom_range(99);
		act = (r < 30) ? ACT_LOAD : (r < 50) ? ACT_WITHDRAW : (r < 70) ? ACT_DEPOSIT : ACT_RANGE;
		// lower index: anywhere, a small hot region, or in range
		r = $urandom_range(99);
		if (live == 0 || r < 12)
			lo = IDX_W'($urandom);
		else if (r < 35)
			lo = IDX_W'($urandom_range(((live < 8) ? live : 8) - 1, 0));
		else
			lo = IDX_W'($urandom_range(live - 1, 0));
		// upper index: mostly a proper range, some reversed or out of range
		r = $urandom_range(99);
		if (live == 0 || r < 10)
			hi = IDX_W'($urandom);
		else if (r < 20 || lo >= live)
			hi = IDX_W'($urandom_range(live - 1, 0));
		else
			hi = IDX_W'($urandom_range(live - 1, lo));
		// amount: full range, small, extremes, near wrap
		r = $urandom_range(99);
		if (r < 40)
			amt = $urandom;
		else if (r < 70)
			amt = $urandom_range(255, 0);
		else if (r < 85)
			case ($urandom_range(3))
				0: amt = '0;
				1: amt = '1;
				2: amt = 32'h8000_0000;
				default: amt = 32'h7fff_ffff;
			endcase
		else
			amt = 32'hffff_ffff - $urandom_range(255, 0);
		send_word(act, lo, hi, amt);
	endtask

	// stimulus
	initial begin
		logic [SIZE_W-1:0] phase_size [9];
		int                phase_items [9];
		phase_size          = '{11'd1024, 11'd1, 11'd2047, 11'd37, 11'd2, 11'd1024,
			11'd600, 11'd0, 11'd1024};
		phase_items         = '{150, 100, 150, 130, 100, 150, 150, 20, 130};
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_data            = '0;
		item_ch.valid       = 1'b0;
		item_ch.action      = '0;
		item_ch.index       = '0;
		item_ch.upper_index = '0;
		item_ch.amount      = '0;
		result_ch.ready     = 1'b0;
		phase_size[8]       = SIZE_W'($urandom_range(2047, 1));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: full size, extremes, wrap, reversed range
		send_word(ACT_LOAD, 10'd0, 10'd0, 32'hffff_ffff);
		send_word(ACT_LOAD, 10'd1023, 10'd0, 32'haaaa_aaaa);
		send_word(ACT_DEPOSIT, 10'd0, 10'd0, 32'd1);
		send_word(ACT_DEPOSIT, 10'h2aa, 10'h155, 32'h5555_5555);
		send_word(ACT_LOAD, 10'h155, 10'h2aa, 32'h8000_0000);
		send_word(ACT_RANGE, 10'd0, 10'd1023, 32'd0);
		send_word(ACT_RANGE, 10'h155, 10'h2aa, 32'd0);
		send_word(ACT_RANGE, 10'h2aa, 10'h155, 32'd0);
		send_word(ACT_RANGE, 10'd1023, 10'd1023, 32'd0);
		send_word(ACT_WITHDRAW, 10'd1023, 10'd0, 32'd0);
		send_word(ACT_WITHDRAW, 10'd1023, 10'd0, 32'd0);
		send_word(ACT_WITHDRAW, 10'h2aa, 10'd0, 32'd0);

		// directed: small size, bounds just past the end
		write_size(11'd16);
		send_word(ACT_LOAD, 10'd16, 10'd0, 32'd5);
		send_word(ACT_DEPOSIT, 10'd15, 10'd0, 32'd7);
		send_word(ACT_RANGE, 10'd0, 10'd16, 32'd0);
		send_word(ACT_RANGE, 10'd16, 10'd2, 32'd0);
		send_word(ACT_RANGE, 10'd2, 10'd15, 32'd0);
		send_word(ACT_WITHDRAW, 10'd1023, 10'd0, 32'd0);

		// directed: size zero rejects everything
		write_size(11'd0);
		send_word(ACT_RANGE, 10'd0, 10'd0, 32'd0);
		send_word(ACT_LOAD, 10'd0, 10'd0, 32'd9);
		send_word(ACT_WITHDRAW, 10'd0, 10'd0, 32'd0);

		// directed: oversized register clamps, hidden elements kept
		write_size(11'd2047);
		send_word(ACT_RANGE, 10'd0, 10'd1023, 32'd0);
		send_word(ACT_DEPOSIT, 10'd1023, 10'd0, 32'hffff_ffff);
		send_word(ACT_RANGE, 10'd1000, 10'd1023, 32'd0);

		// random phases, one with no idling at all
		foreach (phase_size[p]) begin
			write_size(phase_size[p]);
			quiet = (p == 5);
			for (int n = 0; n < phase_items[p]; n++) begin
				if (n == phase_items[p] / 2)
					drain();
				else if (!quiet && $urandom_range(99) >= 55)
					hold_off(pick_gap());
				send_random();
			end
		end
		quiet = 1'b0;

		drain();
		if (ledger.mismatches == 0 && ledger.due_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
